/* design/tbsh_pkg.sv */
// Package for the three-wire bus bit shifter: action and phase codes, field widths
// and the byte and word constants that the shift logic uses.
// No dependencies.
`default_nettype none

package tbsh_pkg;

    localparam int COUNT_W       = 11;  // byte count and byte position width
    localparam int LOAD_ADDR_W   = 10;
    localparam int BYTE_W        = 8;
    localparam int BIT_POS_W     = 3;   // log2 of bits per byte
    localparam int WORD_BYTE_W   = 2;   // log2 of bytes per 32-bit word
    localparam int IN_TDATA_W    = 24;
    localparam int OUT_TDATA_W   = 8;

    localparam logic [COUNT_W-1:0] TRANSFER_BYTES_RESET = 11'd64;

    typedef enum logic [1:0] {
        ACT_LOAD  = 2'd0,
        ACT_START = 2'd1,
        ACT_TICK  = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        PH_DATA      = 2'd0,
        PH_LATCH     = 2'd1,
        PH_CLOCK_LOW = 2'd2,
        PH_CLOCK_HI  = 2'd3
    } phase_t;

endpackage

`default_nettype wire

/* design/tbsh_ram.sv */
// Generic single-write, single-read synchronous RAM with a registered read port.
// Used for the byte buffer of the bit shifter; no package dependencies.
`default_nettype none

module tbsh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output      logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

/* design/three_wire_bus_bit_shifter.sv */
// Top level of the three-wire bus bit shifter: byte buffer loading, start control,
// phase-paced shift-out and the result register. Uses tbsh_pkg and tbsh_ram.
`default_nettype none

// Channel   Direction  Contents
// s_*       in         tuser = action; tdata = load_address, load_byte, phase
// m_*       out        tdata = data, latch, clock, finish line levels; tlast = transfer_done
// cfg_*     in         write of transfer_bytes, no read-back
//
// Every accepted transfer gives one registered result; a new input transfer can be
// taken every cycle unless the result register is full and stalled. The buffer is
// read at the position that the next cycle will use, so its read port sets no limit.
// Reset clears the control state and line levels, not the buffer. A stalled result
// register holds its transfer and stalls the input side until it is taken.

module three_wire_bus_bit_shifter #(
    parameter int BUFFER_DEPTH = 1024   // power of two, 64 to 65536
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // Input stream
    input  wire logic                              s_tvalid,
    output      logic                              s_tready,
    // [9:0] load_address, [17:10] load_byte, [19:18] phase, [23:20] zero
    input  wire logic [tbsh_pkg::IN_TDATA_W-1:0]   s_tdata,
    // [1:0] action
    input  wire logic [1:0]                        s_tuser,
    // Result stream
    output      logic                              m_tvalid,
    input  wire logic                              m_tready,
    // [0] data_line, [1] latch_line, [2] clock_line, [3] finish_line, [7:4] zero
    output      logic [tbsh_pkg::OUT_TDATA_W-1:0]  m_tdata,
    output      logic                              m_tlast,   // transfer_done
    // Configuration
    input  wire logic                              cfg_wen,
    input  wire logic [tbsh_pkg::COUNT_W-1:0]      cfg_wdata
);

    import tbsh_pkg::*;

    localparam int ADDR_W = $clog2(BUFFER_DEPTH);
    // Wide enough for both the byte position and the buffer index.
    localparam int WIDE_W = (ADDR_W > COUNT_W) ? ADDR_W : COUNT_W;

    // Input field unpacking.
    action_t                 in_action;
    logic [LOAD_ADDR_W-1:0]  in_load_address;
    logic [BYTE_W-1:0]       in_load_byte;
    phase_t                  in_phase;

    assign in_action       = action_t'(s_tuser);
    assign in_load_address = s_tdata[9:0];
    assign in_load_byte    = s_tdata[17:10];
    assign in_phase        = phase_t'(s_tdata[19:18]);

    // Control state.
    logic [COUNT_W-1:0]   transfer_bytes_reg;
    logic [BIT_POS_W-1:0] bit_pos_reg, bit_pos_next;
    logic [COUNT_W-1:0]   byte_pos_reg, byte_pos_next;
    logic                 running_reg, running_next;
    logic                 finished_reg, finished_next;
    logic                 data_level_reg, data_level_next;
    logic                 latch_level_reg, latch_level_next;
    logic                 clock_level_reg, clock_level_next;
    logic                 finish_level_reg, finish_level_next;
    logic                 done_next;

    // Result register.
    logic                 m_valid_reg;
    logic [3:0]           m_lines_reg;
    logic                 m_done_reg;

    logic accept;
    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // Buffer access. The read address always follows the position that the next
    // cycle will hold, so the byte under the current position is ready at once.
    logic              ram_wr_en;
    logic [ADDR_W-1:0] ram_wr_addr;
    logic [ADDR_W-1:0] ram_rd_addr;
    logic [BYTE_W-1:0] ram_rd_data;
    logic [WIDE_W-1:0] load_addr_wide;
    logic [WIDE_W-1:0] byte_pos_next_wide;

    assign ram_wr_en          = accept && (in_action == ACT_LOAD);
    assign load_addr_wide     = WIDE_W'(in_load_address);
    assign byte_pos_next_wide = WIDE_W'(byte_pos_next);
    assign ram_wr_addr        = load_addr_wide[ADDR_W-1:0];
    assign ram_rd_addr        = byte_pos_next_wide[ADDR_W-1:0];

    tbsh_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (BUFFER_DEPTH)
    ) u_buffer (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (in_load_byte),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // A load that hits the entry being read in the same cycle bypasses the RAM,
    // which would otherwise return the old byte.
    logic              fwd_valid_reg;
    logic [BYTE_W-1:0] fwd_byte_reg;
    logic [BYTE_W-1:0] shift_byte;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_valid_reg <= 1'b0;
        end else begin
            fwd_valid_reg <= ram_wr_en && (ram_wr_addr == ram_rd_addr);
        end
        fwd_byte_reg <= in_load_byte;
    end

    assign shift_byte = fwd_valid_reg ? fwd_byte_reg : ram_rd_data;

    // Next-state logic for one accepted transfer.
    always_comb begin
        bit_pos_next      = bit_pos_reg;
        byte_pos_next     = byte_pos_reg;
        running_next      = running_reg;
        finished_next     = finished_reg;
        data_level_next   = data_level_reg;
        latch_level_next  = latch_level_reg;
        clock_level_next  = clock_level_reg;
        finish_level_next = finish_level_reg;
        done_next         = 1'b0;

        if (accept) begin
            case (in_action)
                ACT_START: begin
                    // A start is only honored before the first transfer.
                    if (!running_reg && !finished_reg) begin
                        running_next  = 1'b1;
                        bit_pos_next  = '0;
                        byte_pos_next = '0;
                    end
                end
                ACT_TICK: begin
                    if (running_reg) begin
                        case (in_phase)
                            PH_DATA: begin
                                // Bits leave LSB first; the pin carries the inverse.
                                data_level_next = !shift_byte[bit_pos_reg];
                                bit_pos_next    = bit_pos_reg + 1'b1;
                                if (bit_pos_reg == '1) begin
                                    byte_pos_next = byte_pos_reg + 1'b1;
                                end
                            end
                            PH_LATCH: begin
                                latch_level_next = (bit_pos_reg == '0) &&
                                                   (byte_pos_reg[WORD_BYTE_W-1:0] == '0);
                            end
                            PH_CLOCK_LOW: begin
                                clock_level_next = 1'b0;
                            end
                            PH_CLOCK_HI: begin
                                clock_level_next = 1'b1;
                                if (byte_pos_reg == transfer_bytes_reg) begin
                                    finish_level_next = 1'b0;
                                    done_next         = 1'b1;
                                    running_next      = 1'b0;
                                    finished_next     = 1'b1;
                                end
                            end
                            default: begin
                                clock_level_next = clock_level_reg;
                            end
                        endcase
                    end
                end
                default: begin
                    // Loads only touch the buffer; the unused action code does nothing.
                    running_next = running_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            transfer_bytes_reg <= TRANSFER_BYTES_RESET;
            bit_pos_reg        <= '0;
            byte_pos_reg       <= '0;
            running_reg        <= 1'b0;
            finished_reg       <= 1'b0;
            data_level_reg     <= 1'b1;
            latch_level_reg    <= 1'b1;
            clock_level_reg    <= 1'b1;
            finish_level_reg   <= 1'b1;
            m_valid_reg        <= 1'b0;
        end else begin
            if (cfg_wen) begin
                transfer_bytes_reg <= cfg_wdata;
            end
            bit_pos_reg      <= bit_pos_next;
            byte_pos_reg     <= byte_pos_next;
            running_reg      <= running_next;
            finished_reg     <= finished_next;
            data_level_reg   <= data_level_next;
            latch_level_reg  <= latch_level_next;
            clock_level_reg  <= clock_level_next;
            finish_level_reg <= finish_level_next;
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload: the line levels after the item, and the completion flag.
    always_ff @(posedge aclk) begin
        if (accept) begin
            m_lines_reg <= {finish_level_next, clock_level_next,
                            latch_level_next, data_level_next};
            m_done_reg  <= done_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - 4){1'b0}}, m_lines_reg};
    assign m_tlast  = m_done_reg;

    // The block is never running and finished at the same time.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(running_reg && finished_reg))
        else $error("running and finished both set");

    // A completion result always reports the finish line low.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> !m_tdata[3])
        else $error("transfer done with finish line high");

    // A completing phase 3 leaves the block finished and stopped.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && done_next) |=> (finished_reg && !running_reg && !finish_level_reg))
        else $error("completion did not stop the block");

    // Once finished, the bit position no longer moves.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (finished_reg && $past(finished_reg)) |-> $stable(bit_pos_reg))
        else $error("bit position moved after finish");

endmodule

`default_nettype wire

/* tb/three_wire_bus_bit_shifter_checker.sv */
// Checker for the three-wire bus bit shifter: follows the input, configuration and result
// transfers and compares each result with its own prediction of the line levels.
// Depends on tbsh_pkg for the action and phase codes and the field widths.
`timescale 1ns / 1ps

module three_wire_bus_bit_shifter_checker #(
    parameter int BUFFER_DEPTH = 1024
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    input  wire logic                               s_tready,
    input  wire logic [tbsh_pkg::IN_TDATA_W-1:0]    s_tdata,
    input  wire logic [1:0]                         s_tuser,
    input  wire logic                               m_tvalid,
    input  wire logic                               m_tready,
    input  wire logic [tbsh_pkg::OUT_TDATA_W-1:0]   m_tdata,
    input  wire logic                               m_tlast,
    input  wire logic                               cfg_wen,
    input  wire logic [tbsh_pkg::COUNT_W-1:0]       cfg_wdata,
    output int                                      outstanding,
    output int                                      failures
);

    import tbsh_pkg::*;

    typedef struct packed {
        logic data_line;
        logic latch_line;
        logic clock_line;
        logic finish_line;
        logic transfer_done;
    } pin_levels_t;

    pin_levels_t              pin_levels_due[$];
    logic [BYTE_W-1:0]        shadow_buf [BUFFER_DEPTH];
    logic [COUNT_W-1:0]       byte_limit;
    logic [BIT_POS_W-1:0]     bit_idx;
    logic [COUNT_W-1:0]       byte_idx;
    logic                     shifting;
    logic                     stopped;
    pin_levels_t              pins;
    int                       mismatches = 0;

    initial begin
        outstanding = 0;
        failures    = 0;
    end

    // Applies one input item to the shadow state and returns the levels it leaves behind.
    function pin_levels_t next_pin_levels(action_t act, logic [LOAD_ADDR_W-1:0] addr,
                                          logic [BYTE_W-1:0] val, phase_t ph);
        pin_levels_t lv;
        logic        done;
        done = 1'b0;
        case (act)
            ACT_LOAD: begin
                shadow_buf[addr % BUFFER_DEPTH] = val;
            end
            ACT_START: begin
                if (!shifting && !stopped) begin
                    shifting = 1'b1;
                    bit_idx  = '0;
                    byte_idx = '0;
                end
            end
            ACT_TICK: begin
                if (shifting) begin
                    case (ph)
                        PH_DATA: begin
                            pins.data_line = ~shadow_buf[byte_idx % BUFFER_DEPTH][bit_idx];
                            if (bit_idx == '1) begin
                                byte_idx = byte_idx + 1'b1;
                            end
                            bit_idx = bit_idx + 1'b1;
                        end
                        PH_LATCH: begin
                            pins.latch_line = (bit_idx == '0) && (byte_idx[WORD_BYTE_W-1:0] == '0);
                        end
                        PH_CLOCK_LOW: begin
                            pins.clock_line = 1'b0;
                        end
                        default: begin
                            pins.clock_line = 1'b1;
                            if (byte_idx == byte_limit) begin
                                pins.finish_line = 1'b0;
                                done             = 1'b1;
                                shifting         = 1'b0;
                                stopped          = 1'b1;
                            end
                        end
                    endcase
                end
            end
            default: ;
        endcase
        lv = pins;
        lv.transfer_done = done;
        return lv;
    endfunction

    function void check_pin(string pin, logic want, logic got);
        if (got !== want) begin
            $error("%s: expected %b, got %b", pin, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin : watch
        pin_levels_t want;
        if (!aresetn) begin
            byte_limit         = TRANSFER_BYTES_RESET;
            bit_idx            = '0;
            byte_idx           = '0;
            shifting           = 1'b0;
            stopped            = 1'b0;
            pins.data_line     = 1'b1;
            pins.latch_line    = 1'b1;
            pins.clock_line    = 1'b1;
            pins.finish_line   = 1'b1;
            pins.transfer_done = 1'b0;
            pin_levels_due.delete();
        end else begin
            // Results are taken before the input of the same edge is predicted.
            if (m_tvalid && m_tready) begin
                if (pin_levels_due.size() == 0) begin
                    $error("result transfer arrived with no prediction pending");
                    mismatches++;
                end else begin
                    want = pin_levels_due.pop_front();
                    check_pin("data_line", want.data_line, m_tdata[0]);
                    check_pin("latch_line", want.latch_line, m_tdata[1]);
                    check_pin("clock_line", want.clock_line, m_tdata[2]);
                    check_pin("finish_line", want.finish_line, m_tdata[3]);
                    check_pin("transfer_done", want.transfer_done, m_tlast);
                end
            end
            if (cfg_wen) begin
                byte_limit = cfg_wdata;
            end
            if (s_tvalid && s_tready) begin
                pin_levels_due.push_back(next_pin_levels(action_t'(s_tuser), s_tdata[9:0],
                                                         s_tdata[17:10],
                                                         phase_t'(s_tdata[19:18])));
            end
        end
        outstanding <= pin_levels_due.size();
        failures    <= mismatches;
    end

endmodule

/* tb/three_wire_bus_bit_shifter_tb.sv */
// Top of the three-wire bus bit shifter testbench: clock, reset, stimulus, receiver
// back-pressure and the verdict. Depends on tbsh_pkg, the block and the checker module.
`timescale 1ns / 1ps

module three_wire_bus_bit_shifter_tb;
    import tbsh_pkg::*;

    localparam int BUF_DEPTH      = 1024;
    localparam int LIMIT_CYCLES   = 200000;  // far above the slowest legal run
    localparam int SEG_ITEMS      = 380;     // counted items per random segment
    localparam int LONG_HOLD      = 300;     // receiver hold-off that fills the block
    localparam int IDLE_PCT       = 15;
    localparam int MAX_GAP        = 2;
    localparam int PREFILL_ENTRIES = 256;    // the transfer never gets near this many bytes
    localparam int PREFILL_QUIET  = 100;     // first buffer loads go without sender gaps
    localparam int RX_QUIET_FROM  = 900;     // receiver cycles with no stalls at all
    localparam int RX_QUIET_TO    = 1300;
    localparam int SETTLE         = 16;      // cycles allowed after the last result

    logic                    aclk;
    logic                    aresetn;
    logic                    s_tvalid;
    logic                    s_tready;
    // [9:0] load_address, [17:10] load_byte, [19:18] phase, [23:20] zero
    logic [IN_TDATA_W-1:0]   s_tdata;
    // [1:0] action
    logic [1:0]              s_tuser;
    logic                    m_tvalid;
    logic                    m_tready;
    // [0] data_line, [1] latch_line, [2] clock_line, [3] finish_line, [7:4] zero
    logic [OUT_TDATA_W-1:0]  m_tdata;
    logic                    m_tlast;   // transfer_done
    logic                    cfg_wen;
    logic [COUNT_W-1:0]      cfg_wdata;

    int outstanding;
    int check_failures;
    int cycle_count = 0;

    // Stimulus bookkeeping. The block runs one transfer per reset, so the sender tracks
    // how far the transfer has gone in order to pick byte counts that it can still reach.
    logic [COUNT_W-1:0] xfer_limit;
    bit                 xfer_started;
    bit                 xfer_over;
    int                 bits_shifted;
    int                 phase_next;
    int                 items_sent;
    int                 counted;
    int                 cfg_writes;
    bit                 gaps_on;
    bit                 hold_req;

    three_wire_bus_bit_shifter #(
        .BUFFER_DEPTH (BUF_DEPTH)
    ) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata)
    );

    three_wire_bus_bit_shifter_checker #(
        .BUFFER_DEPTH (BUF_DEPTH)
    ) line_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .cfg_wen     (cfg_wen),
        .cfg_wdata   (cfg_wdata),
        .outstanding (outstanding),
        .failures    (check_failures)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // A hung handshake or a lost result ends the run here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Receiver: random stalls, one quiet window with none, and one long
    // hold-off on request so that the result register fills and the input side stalls.
    initial begin : receiver
        int rx_cycles;
        int hold_left;
        bit hold_taken;
        rx_cycles  = 0;
        hold_left  = 0;
        hold_taken = 1'b0;
        m_tready   = 1'b0;
        forever begin
            @(negedge aclk);
            rx_cycles++;
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = LONG_HOLD - 1;
                m_tready  <= 1'b0;
            end else if (rx_cycles >= RX_QUIET_FROM && rx_cycles < RX_QUIET_TO) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Offers one item, starting and ending at a falling edge, and waits for its transfer.
    // A random gap may come first; while the valid is low the data lines carry junk.
    task automatic push_item(input action_t act, input logic [LOAD_ADDR_W-1:0] addr,
                             input logic [BYTE_W-1:0] val, input phase_t ph);
        int gap;
        if (gaps_on && $urandom_range(99) < IDLE_PCT) begin
            gap = $urandom_range(1, MAX_GAP);
            s_tvalid <= 1'b0;
            s_tuser  <= 2'($urandom);
            s_tdata  <= IN_TDATA_W'($urandom);
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {4'b0000, ph, val, addr};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        items_sent++;
        // Only items that change something count toward the segment sizes.
        case (act)
            ACT_LOAD: begin
                counted++;
            end
            ACT_START: begin
                if (!xfer_started && !xfer_over) begin
                    xfer_started = 1'b1;
                    bits_shifted = 0;
                    counted++;
                end
            end
            ACT_TICK: begin
                if (xfer_started) begin
                    counted++;
                    if (ph == PH_DATA) begin
                        bits_shifted++;
                    end else if (ph == PH_CLOCK_HI &&
                                 ((bits_shifted / 8) % (1 << COUNT_W)) == xfer_limit) begin
                        xfer_started = 1'b0;
                        xfer_over    = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    endtask

    // Stops offering and waits at a falling edge until every predicted result has come.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
    endtask

    // Byte count writes happen only with nothing in flight.
    task automatic write_limit(input logic [COUNT_W-1:0] value);
        drain();
        cfg_wen   <= 1'b1;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_wen    <= 1'b0;
        xfer_limit  = value;
        cfg_writes++;
    endtask

    // Mostly timer ticks in the proper phase order with random payload, plus loads,
    // starts, the unused action code and ticks with an arbitrary phase as noise.
    task automatic random_item();
        int pick;
        pick = $urandom_range(99);
        if (pick < 10) begin
            push_item(ACT_LOAD, LOAD_ADDR_W'($urandom_range(BUF_DEPTH - 1)),
                      BYTE_W'($urandom_range(255)), phase_t'($urandom_range(3)));
        end else if (pick < 12) begin
            push_item(ACT_START, LOAD_ADDR_W'($urandom), BYTE_W'($urandom),
                      phase_t'($urandom_range(3)));
        end else if (pick < 14) begin
            push_item(ACT_NONE, LOAD_ADDR_W'($urandom), BYTE_W'($urandom),
                      phase_t'($urandom_range(3)));
        end else if (pick < 17) begin
            push_item(ACT_TICK, LOAD_ADDR_W'($urandom), BYTE_W'($urandom),
                      phase_t'($urandom_range(3)));
        end else begin
            push_item(ACT_TICK, LOAD_ADDR_W'($urandom), BYTE_W'($urandom),
                      phase_t'(phase_next));
            phase_next = (phase_next + 1) % 4;
        end
    endtask

    initial begin : stimulus
        int i;
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = ACT_LOAD;
        cfg_wen      = 1'b0;
        cfg_wdata    = '0;
        xfer_limit   = TRANSFER_BYTES_RESET;
        xfer_started = 1'b0;
        xfer_over    = 1'b0;
        bits_shifted = 0;
        phase_next   = 0;
        items_sent   = 0;
        counted      = 0;
        cfg_writes   = 0;
        gaps_on      = 1'b0;
        hold_req     = 1'b0;

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part. With no transfer running, every tick and the unused action code
        // must leave all lines at their reset levels.
        write_limit(11'd1023);
        push_item(ACT_TICK, '0, '0, PH_DATA);
        push_item(ACT_TICK, '1, '1, PH_LATCH);
        push_item(ACT_TICK, '0, '1, PH_CLOCK_LOW);
        push_item(ACT_TICK, '1, '0, PH_CLOCK_HI);
        push_item(ACT_NONE, '1, '1, PH_CLOCK_HI);

        // Every buffer entry that the transfer can reach gets written before it starts.
        for (i = 0; i < PREFILL_ENTRIES; i++) begin
            gaps_on = (i >= PREFILL_QUIET);
            push_item(ACT_LOAD, LOAD_ADDR_W'(i), BYTE_W'($urandom_range(255)),
                      phase_t'($urandom_range(3)));
        end
        // Extreme bytes at the first bytes to be shifted and at the top address.
        push_item(ACT_LOAD, 10'd0, 8'hFF, PH_DATA);
        push_item(ACT_LOAD, 10'd1, 8'h00, PH_CLOCK_HI);
        push_item(ACT_LOAD, 10'd1023, 8'h00, PH_LATCH);
        push_item(ACT_LOAD, 10'd2, 8'hA5, PH_CLOCK_LOW);

        // Byte count of 1024, then a start and a second start that must be ignored.
        write_limit(11'd1024);
        push_item(ACT_START, '0, '0, PH_DATA);
        push_item(ACT_START, '1, '1, PH_CLOCK_HI);

        // First random segment. Part way in, the receiver holds off for a long stretch
        // while items keep coming.
        counted = 0;
        while (counted < SEG_ITEMS) begin
            if (counted == 100) begin
                hold_req = 1'b1;
            end
            random_item();
        end

        // A byte count of 1 written mid-transfer: the position is already past it,
        // so the transfer keeps going.
        write_limit(11'd1);
        while (counted < 2 * SEG_ITEMS) begin
            random_item();
        end

        // A count a few bytes ahead of the current position lets the transfer complete.
        write_limit(COUNT_W'(bits_shifted / 8 + 6));
        while (!xfer_over) begin
            random_item();
        end

        // After completion starts and ticks are dead; loads still go into the buffer.
        repeat (24) random_item();

        drain();
        repeat (SETTLE) @(negedge aclk);

        $display("Run offered %0d input transfers, shifted %0d bits, made %0d count writes.",
                 items_sent, bits_shifted, cfg_writes);
        $display("Receiver held off %0d cycles once; transfer completion %0s.",
                 LONG_HOLD, xfer_over ? "reached" : "not reached");
        if (check_failures == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

/* filelist.f */
design/tbsh_pkg.sv
design/tbsh_ram.sv
design/three_wire_bus_bit_shifter.sv
tb/three_wire_bus_bit_shifter_checker.sv
tb/three_wire_bus_bit_shifter_tb.sv
